@@ rtl/pct_pkg.sv @@
// Shared types and constants for the pair contact test pipeline.
// No dependencies; used by every module under rtl/.
package pct_pkg;

	localparam int SQ_STEPS  = 32;  // one result bit per sqrt stage
	localparam int DIV_STEPS = 15;  // quotient bits of the normal divide
	localparam int RAD_W     = 64;
	localparam int REM_W     = 35;

	localparam logic [15:0] Q14_ONE     = 16'h4000;
	localparam logic [15:0] Q14_NEG_ONE = 16'hC000;

	localparam logic [1:0] KIND_STATIC = 2'd0;
	localparam logic       SHAPE_CIRCLE = 1'b0;
	localparam logic       SHAPE_BOX    = 1'b1;

	// per-pair side data carried alongside the arithmetic
	typedef struct packed {
		logic        circ;   // circle pair in contact
		logic        box;    // box pair in contact
		logic        sgn_x;
		logic        sgn_y;
		logic [30:0] rs;
		logic [30:0] ax;
		logic [30:0] ay;
		logic [15:0] bnx;
		logic [15:0] bny;
		logic [30:0] bpen;
	} ctl_t;

endpackage

@@ rtl/pct_front.sv @@
// Front end: offsets, magnitudes, squares, exact circle test and full box test.
// Three register stages. Depends on pct_pkg.
module pct_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [31:0]       pos_a_x,
	input  logic [31:0]       pos_a_y,
	input  logic [31:0]       pos_b_x,
	input  logic [31:0]       pos_b_y,
	input  logic [29:0]       size_a_x,
	input  logic [29:0]       size_a_y,
	input  logic [29:0]       size_b_x,
	input  logic [29:0]       size_b_y,
	input  logic              shape_a,
	input  logic              shape_b,
	input  logic [1:0]        kind_a,
	input  logic [1:0]        kind_b,
	output logic              out_vld,
	output logic [62:0]       dsq,
	output pct_pkg::ctl_t     ctl
);

	logic [32:0] dx, dy, ax_c, ay_c;
	logic [30:0] rs_c, hy_c;
	logic        active;

	always_comb begin
		dx     = {pos_b_x[31], pos_b_x} - {pos_a_x[31], pos_a_x};
		dy     = {pos_b_y[31], pos_b_y} - {pos_a_y[31], pos_a_y};
		ax_c   = dx[32] ? (33'd0 - dx) : dx;
		ay_c   = dy[32] ? (33'd0 - dy) : dy;
		rs_c   = {1'b0, size_a_x} + {1'b0, size_b_x};
		hy_c   = {1'b0, size_a_y} + {1'b0, size_b_y};
		active = !(kind_a == pct_pkg::KIND_STATIC && kind_b == pct_pkg::KIND_STATIC);
	end

	// stage 1
	logic        vld_s1, circ_s1, box_s1, sx_s1, sy_s1;
	logic [30:0] rs_s1, ax_s1, ay_s1;
	logic [33:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			circ_s1 <= active && shape_a == pct_pkg::SHAPE_CIRCLE
				&& shape_b == pct_pkg::SHAPE_CIRCLE
				&& ax_c <= {2'b0, rs_c} && ay_c <= {2'b0, rs_c};
			box_s1  <= active && shape_a == pct_pkg::SHAPE_BOX
				&& shape_b == pct_pkg::SHAPE_BOX;
			sx_s1   <= dx[32];
			sy_s1   <= dy[32];
			rs_s1   <= rs_c;
			ax_s1   <= ax_c[30:0];
			ay_s1   <= ay_c[30:0];
			px_s1   <= {3'b0, rs_c} - {1'b0, ax_c};
			py_s1   <= {3'b0, hy_c} - {1'b0, ay_c};
		end
	end

	// stage 2: squares and box decision
	logic        vld_s2, circ_s2;
	logic [61:0] ax2_s2, ay2_s2, rs2_s2;
	pct_pkg::ctl_t ctl_s2;
	logic        px_pos, py_pos, x_axis;

	always_comb begin
		px_pos = !px_s1[33] && px_s1 != 34'd0;
		py_pos = !py_s1[33] && py_s1 != 34'd0;
		x_axis = $signed(px_s1) < $signed(py_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			circ_s2      <= circ_s1;
			ax2_s2       <= {31'd0, ax_s1} * {31'd0, ax_s1};
			ay2_s2       <= {31'd0, ay_s1} * {31'd0, ay_s1};
			rs2_s2       <= {31'd0, rs_s1} * {31'd0, rs_s1};
			ctl_s2.circ  <= 1'b0;
			ctl_s2.box   <= box_s1 && px_pos && py_pos;
			ctl_s2.sgn_x <= sx_s1;
			ctl_s2.sgn_y <= sy_s1;
			ctl_s2.rs    <= rs_s1;
			ctl_s2.ax    <= ax_s1;
			ctl_s2.ay    <= ay_s1;
			ctl_s2.bnx   <= x_axis ? (sx_s1 ? pct_pkg::Q14_NEG_ONE : pct_pkg::Q14_ONE) : 16'd0;
			ctl_s2.bny   <= x_axis ? 16'd0 : (sy_s1 ? pct_pkg::Q14_NEG_ONE : pct_pkg::Q14_ONE);
			ctl_s2.bpen  <= x_axis ? px_s1[30:0] : py_s1[30:0];
		end
	end

	// stage 3: exact squared-distance compare
	logic        vld_s3;
	logic [62:0] dsq_c;
	assign dsq_c = {1'b0, ax2_s2} + {1'b0, ay2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsq <= dsq_c;
			ctl <= '{circ: circ_s2 && dsq_c <= {1'b0, rs2_s2}, box: ctl_s2.box,
				sgn_x: ctl_s2.sgn_x, sgn_y: ctl_s2.sgn_y, rs: ctl_s2.rs,
				ax: ctl_s2.ax, ay: ctl_s2.ay, bnx: ctl_s2.bnx, bny: ctl_s2.bny,
				bpen: ctl_s2.bpen};
		end
	end

	assign out_vld = vld_s3;

endmodule

@@ rtl/pct_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on pct_pkg.
module pct_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [62:0]   rad,
	input  pct_pkg::ctl_t in_ctl,
	output logic          out_vld,
	output logic [31:0]   root,
	output pct_pkg::ctl_t out_ctl
);

	localparam int N = pct_pkg::SQ_STEPS;

	logic                       vld_s  [0:N-1];
	logic [pct_pkg::REM_W-1:0]  rem_s  [0:N-1];
	logic [31:0]                root_s [0:N-1];
	logic [pct_pkg::RAD_W-1:0]  rad_s  [0:N-1];
	pct_pkg::ctl_t              ctl_s  [0:N-1];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                      v_in;
		logic [pct_pkg::REM_W-1:0] r_in;
		logic [31:0]               q_in;
		logic [pct_pkg::RAD_W-1:0] d_in;
		pct_pkg::ctl_t             c_in;
		logic [pct_pkg::REM_W-1:0] cur, trial;
		logic                      ge;

		if (i == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = '0;
			assign q_in = '0;
			assign d_in = {1'b0, rad};
			assign c_in = in_ctl;
		end else begin : g_next
			assign v_in = vld_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = root_s[i-1];
			assign d_in = rad_s[i-1];
			assign c_in = ctl_s[i-1];
		end

		always_comb begin
			cur   = {r_in[pct_pkg::REM_W-3:0], d_in[pct_pkg::RAD_W-1 -: 2]};
			trial = {1'b0, q_in, 2'b01};
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? cur - trial : cur;
				root_s[i] <= {q_in[30:0], ge};
				rad_s[i]  <= {d_in[pct_pkg::RAD_W-3:0], 2'b00};
				ctl_s[i]  <= c_in;
			end
		end
	end

	assign out_vld = vld_s[N-1];
	assign root    = root_s[N-1];
	assign out_ctl = ctl_s[N-1];

endmodule

@@ rtl/pct_div.sv @@
// Pipelined restoring divide of both offset magnitudes by the distance,
// giving Q1.14 normal magnitudes. Depends on pct_pkg.
module pct_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [31:0]   dist_in,
	input  pct_pkg::ctl_t in_ctl,
	output logic          out_vld,
	output logic [14:0]   qx,
	output logic [14:0]   qy,
	output logic [31:0]   out_dist,
	output pct_pkg::ctl_t out_ctl
);

	localparam int N = pct_pkg::DIV_STEPS;

	logic          vld_s [0:N-1];
	logic [32:0]   rx_s  [0:N-1];
	logic [32:0]   ry_s  [0:N-1];
	logic [14:0]   qx_s  [0:N-1];
	logic [14:0]   qy_s  [0:N-1];
	logic [31:0]   d_s   [0:N-1];
	pct_pkg::ctl_t ctl_s [0:N-1];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic          v_in;
		logic [32:0]   tx, ty;
		logic [14:0]   qx_in, qy_in;
		logic [31:0]   d_in;
		pct_pkg::ctl_t c_in;
		logic          gx, gy;

		// first step takes the magnitude as is (it never exceeds the distance)
		if (i == 0) begin : g_first
			assign v_in  = in_vld;
			assign tx    = {2'b0, in_ctl.ax};
			assign ty    = {2'b0, in_ctl.ay};
			assign qx_in = '0;
			assign qy_in = '0;
			assign d_in  = dist_in;
			assign c_in  = in_ctl;
		end else begin : g_next
			assign v_in  = vld_s[i-1];
			assign tx    = {rx_s[i-1][31:0], 1'b0};
			assign ty    = {ry_s[i-1][31:0], 1'b0};
			assign qx_in = qx_s[i-1];
			assign qy_in = qy_s[i-1];
			assign d_in  = d_s[i-1];
			assign c_in  = ctl_s[i-1];
		end

		assign gx = tx >= {1'b0, d_in};
		assign gy = ty >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[i]  <= gx ? tx - {1'b0, d_in} : tx;
				ry_s[i]  <= gy ? ty - {1'b0, d_in} : ty;
				qx_s[i]  <= {qx_in[13:0], gx};
				qy_s[i]  <= {qy_in[13:0], gy};
				d_s[i]   <= d_in;
				ctl_s[i] <= c_in;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign qx       = qx_s[N-1];
	assign qy       = qy_s[N-1];
	assign out_dist = d_s[N-1];
	assign out_ctl  = ctl_s[N-1];

endmodule

@@ rtl/pair_contact_test.sv @@
// Pair contact test: each input transaction passes through 3 front stages, 32 square-root
// stages, 15 divide stages and 1 output register on its way to the result.
// Throughput one pair per cycle; the whole pipeline holds while the output
// register is full and not taken. arst_n empties all valid bits; payload
// registers are not reset. Depends on pct_pkg, pct_front, pct_sqrt, pct_div.
module pair_contact_test (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_a_x[31:0] pos_a_y[63:32] pos_b_x[95:64] pos_b_y[127:96]
	// size_a_x[157:128] size_a_y[187:158] size_b_x[217:188] size_b_y[247:218]
	input  logic [247:0] s_axis_tdata,
	// shape_a[0] shape_b[1] kind_a[3:2] kind_b[5:4]
	input  logic [5:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// normal_x[15:0] normal_y[31:16] penetration[62:32], zero pad [63]
	output logic [63:0]  m_axis_tdata,
	// collided[0]
	output logic         m_axis_tuser
);

	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic          f_vld, q_vld, d_vld;
	logic [62:0]   dsq;
	logic [31:0]   root, div_dist;
	logic [14:0]   qx, qy;
	pct_pkg::ctl_t f_ctl, q_ctl, d_ctl;

	pct_front u_front (
		.clk, .arst_n, .en,
		.in_vld   (s_axis_tvalid && en),
		.pos_a_x  (s_axis_tdata[31:0]),
		.pos_a_y  (s_axis_tdata[63:32]),
		.pos_b_x  (s_axis_tdata[95:64]),
		.pos_b_y  (s_axis_tdata[127:96]),
		.size_a_x (s_axis_tdata[157:128]),
		.size_a_y (s_axis_tdata[187:158]),
		.size_b_x (s_axis_tdata[217:188]),
		.size_b_y (s_axis_tdata[247:218]),
		.shape_a  (s_axis_tuser[0]),
		.shape_b  (s_axis_tuser[1]),
		.kind_a   (s_axis_tuser[3:2]),
		.kind_b   (s_axis_tuser[5:4]),
		.out_vld  (f_vld),
		.dsq      (dsq),
		.ctl      (f_ctl)
	);

	pct_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_vld  (f_vld),
		.rad     (dsq),
		.in_ctl  (f_ctl),
		.out_vld (q_vld),
		.root    (root),
		.out_ctl (q_ctl)
	);

	pct_div u_div (
		.clk, .arst_n, .en,
		.in_vld   (q_vld),
		.dist_in  (root),
		.in_ctl   (q_ctl),
		.out_vld  (d_vld),
		.qx       (qx),
		.qy       (qy),
		.out_dist (div_dist),
		.out_ctl  (d_ctl)
	);

	logic [15:0] nx, ny, mx, my;
	logic [30:0] pen;
	logic        hit;

	always_comb begin
		mx  = {1'b0, qx};
		my  = {1'b0, qy};
		hit = d_ctl.circ || d_ctl.box;
		nx  = '0;
		ny  = '0;
		pen = '0;
		if (d_ctl.box) begin
			nx  = d_ctl.bnx;
			ny  = d_ctl.bny;
			pen = d_ctl.bpen;
		end else if (d_ctl.circ) begin
			if (div_dist == 32'd0) begin
				// coincident centres
				ny  = pct_pkg::Q14_ONE;
				pen = d_ctl.rs;
			end else begin
				nx  = d_ctl.sgn_x ? 16'd0 - mx : mx;
				ny  = d_ctl.sgn_y ? 16'd0 - my : my;
				pen = d_ctl.rs - div_dist[30:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {1'b0, pen, ny, nx};
			m_axis_tuser <= hit;
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
		else $error("no-contact result carries nonzero payload");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		$signed(m_axis_tdata[15:0]) <= 16'sd16384 && $signed(m_axis_tdata[15:0]) >= -16'sd16384
		&& $signed(m_axis_tdata[31:16]) <= 16'sd16384
		&& $signed(m_axis_tdata[31:16]) >= -16'sd16384)
		else $error("normal component out of unit range");

	// the larger offset component always gives at least half of unit length
	a_hit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] != 32'd0)
		else $error("contact result has a zero normal");

endmodule

@@ tb/pair_contact_test_tb.sv @@
// Testbench for pair_contact_test: directed table plus random candidate pairs,
// scored against an in-bench contact predictor. Depends on pct_pkg and the RTL.
`timescale 1ns / 1ps

module pair_contact_test_tb;

	typedef struct {
		logic signed [31:0] xa, ya, xb, yb;
		logic [29:0]        sax, say, sbx, sby;
		logic               sha, shb;
		logic [1:0]         ka, kb;
	} pair_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] nx, ny;
		logic [30:0]        pen;
	} contact_t;

	typedef struct {
		pair_t    p;
		logic     has_exp;
		contact_t c;
	} row_t;

	localparam int RAND_PAIRS = 600;
	localparam int CYCLE_LIMIT = 200000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [247:0] s_axis_tdata = '0;
	logic [5:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;

	contact_t contact_q[$];
	int       errors = 0;
	int       cycles = 0;
	bit       quiet = 1'b0;   // no idling on either side
	row_t     rows[$];

	pair_contact_test DUT (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		r = 0;
		for (int b = 31; b >= 0; b--)
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
				r |= 64'd1 << b;
		return r;
	endfunction

	function automatic contact_t predict_contact(input pair_t p);
		contact_t           c;
		logic signed [63:0] dx, dy, px, py;
		logic [63:0]        ax, ay, rs, d, q;
		c = '{default: '0};
		dx = 64'(p.xb) - 64'(p.xa);
		dy = 64'(p.yb) - 64'(p.ya);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (p.ka == pct_pkg::KIND_STATIC && p.kb == pct_pkg::KIND_STATIC) return c;
		if (p.sha == pct_pkg::SHAPE_CIRCLE && p.shb == pct_pkg::SHAPE_CIRCLE) begin
			rs = 64'(p.sax) + 64'(p.sbx);
			if (ax > rs || ay > rs || ax * ax + ay * ay > rs * rs) return c;
			d = int_sqrt(ax * ax + ay * ay);
			c.hit = 1'b1;
			if (d > 0) begin
				q = (ax * 16384) / d;
				c.nx = dx < 0 ? -16'(q) : 16'(q);
				q = (ay * 16384) / d;
				c.ny = dy < 0 ? -16'(q) : 16'(q);
				c.pen = 31'(rs - d);
			end else begin
				c.ny = pct_pkg::Q14_ONE;
				c.pen = 31'(rs);
			end
		end else if (p.sha == pct_pkg::SHAPE_BOX && p.shb == pct_pkg::SHAPE_BOX) begin
			px = 64'(p.sax) + 64'(p.sbx) - 64'(ax);
			py = 64'(p.say) + 64'(p.sby) - 64'(ay);
			if (px <= 0 || py <= 0) return c;
			c.hit = 1'b1;
			if (px < py) begin
				c.nx = dx < 0 ? pct_pkg::Q14_NEG_ONE : pct_pkg::Q14_ONE;
				c.pen = 31'(px);
			end else begin
				c.ny = dy < 0 ? pct_pkg::Q14_NEG_ONE : pct_pkg::Q14_ONE;
				c.pen = 31'(py);
			end
		end
		return c;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int    mode;
		logic [29:0] m;
		mode = $urandom_range(0, 9);
		p.sha = $urandom_range(0, 1);
		p.shb = (mode < 8) ? p.sha : $urandom_range(0, 1);
		p.ka = $urandom_range(0, 3);
		p.kb = $urandom_range(0, 3);
		p.xa = $urandom; p.ya = $urandom;
		m = (mode < 4) ? 30'h3ff_ffff >> $urandom_range(0, 20) : 30'h3fff_ffff;
		p.sax = $urandom & m; p.say = $urandom & m;
		p.sbx = $urandom & m; p.sby = $urandom & m;
		if (mode < 7) begin
			// near contact: B offset inside about the summed sizes
			p.xb = p.xa + $signed(32'($urandom_range(0, 2 * (p.sax + p.sbx))))
				- $signed(32'(p.sax + p.sbx));
			p.yb = p.ya + $signed(32'($urandom_range(0, 2 * (p.say + p.sby))))
				- $signed(32'(p.say + p.sby));
			if (p.sha == pct_pkg::SHAPE_CIRCLE && $urandom_range(0, 3) == 0) p.yb = p.ya;
		end else begin
			p.xb = $urandom; p.yb = $urandom;
		end
		return p;
	endfunction

	task automatic send_pair(input pair_t p);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.sby, p.sbx, p.say, p.sax, p.yb, p.xb, p.ya, p.xa};
		s_axis_tuser <= {p.kb, p.ka, p.shb, p.sha};
		contact_q.push_back(predict_contact(p));
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic idle_sender();
		if (!quiet && $urandom_range(0, 99) < 28) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 28);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
		m_axis_tready <= arst_n && (quiet || $urandom_range(0, 99) >= 28);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (contact_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				contact_t e;
				e = contact_q.pop_front();
				if (m_axis_tuser !== e.hit) begin
					$error("collided exp %0d got %0d", e.hit, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[15:0] !== e.nx) begin
					$error("normal_x exp %0d got %0d", e.nx, $signed(m_axis_tdata[15:0]));
					errors++;
				end
				if (m_axis_tdata[31:16] !== e.ny) begin
					$error("normal_y exp %0d got %0d", e.ny, $signed(m_axis_tdata[31:16]));
					errors++;
				end
				if (m_axis_tdata[62:32] !== e.pen) begin
					$error("penetration exp %0d got %0d", e.pen, m_axis_tdata[62:32]);
					errors++;
				end
			end
		end
	end

	function automatic pair_t mk(input logic signed [31:0] xa, ya, xb, yb,
			input logic [29:0] sax, say, sbx, sby, input logic sha, shb,
			input logic [1:0] ka, kb);
		pair_t p;
		p = '{xa, ya, xb, yb, sax, say, sbx, sby, sha, shb, ka, kb};
		return p;
	endfunction

	function automatic contact_t ct(input logic h, input logic [15:0] nx, ny,
			input logic [30:0] pen);
		contact_t c;
		c = '{h, nx, ny, pen};
		return c;
	endfunction

	task automatic add_row(input pair_t p, input logic has, input contact_t c);
		row_t r;
		r = '{p, has, c};
		rows.push_back(r);
	endtask

	initial begin
		contact_t got;
		logic [29:0] mx;
		mx = 30'h3fff_ffff;
		// static pair, mixed shapes, coincident, touching, just-apart and offset circles
		add_row(mk(0, 0, 0, 0, 100, 0, 100, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			0, 0), 1, ct(0, 0, 0, 0));
		add_row(mk(0, 0, 0, 0, 100, 100, 100, 100, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_BOX,
			2, 2), 1, ct(0, 0, 0, 0));
		add_row(mk(0, 0, 0, 0, 100, 100, 100, 100, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_CIRCLE,
			1, 2), 1, ct(0, 0, 0, 0));
		add_row(mk(5, 5, 5, 5, 100, 0, 50, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			2, 0), 1, ct(1, 0, pct_pkg::Q14_ONE, 150));
		add_row(mk(0, 0, 200, 0, 100, 0, 100, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			2, 2), 1, ct(1, pct_pkg::Q14_ONE, 0, 0));
		add_row(mk(0, 0, 0, -201, 100, 0, 100, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			3, 3), 1, ct(0, 0, 0, 0));
		add_row(mk(0, 0, 30, 40, 100, 0, 0, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			1, 0), 0, ct(0, 0, 0, 0));
		add_row(mk(0, 0, -30, 40, 100, 0, 0, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			1, 0), 0, ct(0, 0, 0, 0));
		// boxes: zero offset is positive, equal overlaps pick y, edge touch and static pair miss
		add_row(mk(0, 0, 0, 0, 10, 10, 10, 10, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX,
			2, 2), 1, ct(1, 0, pct_pkg::Q14_ONE, 20));
		add_row(mk(0, 0, -15, 0, 10, 100, 10, 100, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX,
			2, 1), 1, ct(1, pct_pkg::Q14_NEG_ONE, 0, 5));
		add_row(mk(0, 0, 0, -15, 100, 10, 100, 10, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX,
			0, 1), 1, ct(1, 0, pct_pkg::Q14_NEG_ONE, 5));
		add_row(mk(0, 0, 20, 0, 10, 10, 10, 10, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX,
			2, 2), 1, ct(0, 0, 0, 0));
		add_row(mk(0, 0, 0, 0, 10, 10, 10, 10, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX,
			0, 0), 1, ct(0, 0, 0, 0));
		// extremes of positions and sizes
		add_row(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
			mx, mx, mx, mx, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE, 2, 2), 0,
			ct(0, 0, 0, 0));
		add_row(mk(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			mx, mx, mx, mx, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX, 2, 2), 0, ct(0, 0, 0, 0));
		add_row(mk(32'sh7fff_ffff, 0, 32'sh4000_0000, 1, mx, mx, mx, mx,
			pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE, 1, 1), 0, ct(0, 0, 0, 0));
		add_row(mk(-1, -1, 0, 0, mx, mx, mx, mx, pct_pkg::SHAPE_BOX, pct_pkg::SHAPE_BOX,
			1, 1), 0, ct(0, 0, 0, 0));
		add_row(mk(0, 0, 1, 1, 0, 0, 0, 0, pct_pkg::SHAPE_CIRCLE, pct_pkg::SHAPE_CIRCLE,
			2, 2), 1, ct(0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				got = predict_contact(rows[i].p);
				if (got != rows[i].c) begin
					$error("table row %0d disagrees with predictor", i);
					errors++;
				end
			end
			send_pair(rows[i].p);
			idle_sender();
		end
		for (int n = 0; n < RAND_PAIRS; n++) begin
			quiet = (n >= 200 && n < 300);
			if (n == 400) begin
				// hold off until the pipe drains
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (contact_q.size() != 0);
			end
			send_pair(random_pair());
			idle_sender();
		end
		s_axis_tvalid <= 1'b0;
		while (contact_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pct_pkg.sv
rtl/pct_front.sv
rtl/pct_sqrt.sv
rtl/pct_div.sv
rtl/pair_contact_test.sv
tb/pair_contact_test_tb.sv
